// ----- rtl/lazy_range_add_set_sum_tree_assert.svh -----
// assertion macros for the range add, assign and sum block
`ifndef LAZY_RANGE_ADD_SET_SUM_TREE_ASSERT_SVH
`define LAZY_RANGE_ADD_SET_SUM_TREE_ASSERT_SVH

// plain clocked property with reset disable
`define LRAST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define LRAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LRAST_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/lrast_pkg.sv -----
// shared constants and control types for the range add, assign and sum block
package lrast_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned IDX_IN_W   = 10;
  localparam int unsigned OPND_W     = 32;
  localparam int unsigned SUM_W      = 64;
  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_SUM  = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd;
    logic wr;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic clr_last;
  } sts_t;

endpackage

// ----- rtl/lrast_datapath.sv -----
// element store, range counter and sum accumulator
module lrast_datapath #(
  parameter int unsigned LEAVES = lrast_pkg::LEAVES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrast_pkg::ctl_t                ctl_i,
  output lrast_pkg::sts_t                sts_o,
  input  logic                           cfg_we_i,
  input  logic [lrast_pkg::LEN_W-1:0]    cfg_wdata_i,
  input  logic [1:0]                     command_i,
  input  logic [lrast_pkg::IDX_IN_W-1:0] left_index_i,
  input  logic [lrast_pkg::IDX_IN_W-1:0] right_index_i,
  input  logic signed [lrast_pkg::OPND_W-1:0] operand_value_i,
  output logic signed [lrast_pkg::SUM_W-1:0]  range_sum_o
);
  import lrast_pkg::*;

  localparam int unsigned IW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned EW = ((IW > IDX_IN_W) ? IW : IDX_IN_W) + 1;

  logic [SUM_W-1:0] mem [LEAVES];

  logic [LEN_W-1:0] active_length_q;
  logic [IW-1:0]    addr_q, end_q;
  logic [1:0]       op_q;
  logic [SUM_W-1:0] x_q, rdata_q, acc_q;

  logic [EW-1:0]    len_e, a_e, b_e;
  logic             empty;
  logic             we;
  logic [SUM_W-1:0] wd;

  always_comb begin
    len_e = EW'(active_length_q);
    if (len_e > EW'(LEAVES)) begin
      len_e = EW'(LEAVES);
    end
    a_e = EW'(left_index_i);
    b_e = EW'(right_index_i);
    if (len_e != '0 && b_e > len_e - EW'(1)) begin
      b_e = len_e - EW'(1);
    end
    empty = (len_e == '0) || (a_e > b_e);
  end

  assign sts_o.empty    = empty;
  assign sts_o.last     = (addr_q == end_q);
  assign sts_o.clr_last = (addr_q == IW'(LEAVES - 1));

  always_comb begin
    we = 1'b0;
    wd = '0;
    if (ctl_i.clr) begin
      we = 1'b1;
    end else if (ctl_i.wr && op_q != CMD_SUM) begin
      we = 1'b1;
      wd = (op_q == CMD_SET) ? x_q : rdata_q + x_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr_q] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_length_q <= LEN_RESET;
      addr_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        active_length_q <= cfg_wdata_i;
      end
      if (ctl_i.load) begin
        addr_q <= a_e[IW-1:0];
      end else if (ctl_i.clr || ctl_i.wr) begin
        addr_q <= addr_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      end_q <= b_e[IW-1:0];
      op_q  <= command_i;
      x_q   <= SUM_W'(operand_value_i);
      acc_q <= '0;
    end else if (ctl_i.wr) begin
      acc_q <= acc_q + rdata_q;
    end
  end

  assign range_sum_o = acc_q;

endmodule

// ----- rtl/lrast_ctrl.sv -----
// command sequencer: clearing pass, element sweep and result strobe
module lrast_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      command_i,
  input  lrast_pkg::sts_t sts_i,
  output lrast_pkg::ctl_t ctl_o,
  output logic            valid_o
);
  import lrast_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_WR, S_DONE
  } state_e;

  state_e state_q;
  logic   ctl_is_sum_q;
  logic   accept;

  assign busy   = !(state_q == S_IDLE || state_q == S_DONE);
  assign accept = start && !busy;

  assign ctl_o.load = accept;
  assign ctl_o.clr  = (state_q == S_CLEAR);
  assign ctl_o.rd   = (state_q == S_RD);
  assign ctl_o.wr   = (state_q == S_WR);
  assign valid_o    = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE, S_DONE: begin
          if (accept && command_i inside {CMD_ADD, CMD_SET, CMD_SUM} && !sts_i.empty) begin
            state_q <= S_RD;
          end else if (accept && command_i == CMD_SUM) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (!sts_i.last) begin
            state_q <= S_RD;
          end else if (ctl_is_sum_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_is_sum_q <= 1'b0;
    end else if (accept) begin
      ctl_is_sum_q <= (command_i == CMD_SUM);
    end
  end

endmodule

// ----- rtl/lazy_range_add_set_sum_tree.sv -----
// top level of the range add, assign and sum block
// Each word is one command over an inclusive index range, clipped to the active length.
// The single-port element store handles one element per read cycle and one per write
// cycle, so a command sweeps each element of its range through a read state and then a
// write state with busy high, and a query strobes its sum on the cycle after the last
// write; an empty range or an unused command code leaves busy low. After reset a clearing
// pass zeroes the store with busy high. The sum is shown for exactly one cycle and cannot
// be stalled.
module lazy_range_add_set_sum_tree #(
  parameter int unsigned LEAVES = lrast_pkg::LEAVES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command_i,
  input  logic [lrast_pkg::IDX_IN_W-1:0]      left_index_i,
  input  logic [lrast_pkg::IDX_IN_W-1:0]      right_index_i,
  input  logic signed [lrast_pkg::OPND_W-1:0] operand_value_i,
  input  logic                                cfg_we_i,
  input  logic [lrast_pkg::LEN_W-1:0]         cfg_wdata_i,
  output logic                                range_sum_valid_o,
  output logic signed [lrast_pkg::SUM_W-1:0]  range_sum_o
);
  import lrast_pkg::*;

  ctl_t ctl;
  sts_t sts;

  lrast_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .sts_i     (sts),
    .ctl_o     (ctl),
    .valid_o   (range_sum_valid_o)
  );

  lrast_datapath #(.LEAVES(LEAVES)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (command_i),
    .left_index_i    (left_index_i),
    .right_index_i   (right_index_i),
    .operand_value_i (operand_value_i),
    .range_sum_o     (range_sum_o)
  );

endmodule

// ----- rtl/lrast_checker.sv -----
// port-level checks for the range add, assign and sum block
`include "lazy_range_add_set_sum_tree_assert.svh"

module lrast_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  command_i,
  input logic [9:0]  left_index_i,
  input logic [9:0]  right_index_i,
  input logic        range_sum_valid_o,
  input logic [63:0] range_sum_o
);
  import lrast_pkg::*;

  logic upd_acc;
  logic empty_qry;
  logic zero_strobe;

  assign upd_acc     = start && !busy && command_i != CMD_SUM;
  assign empty_qry   = start && !busy && command_i == CMD_SUM && left_index_i > right_index_i;
  assign zero_strobe = range_sum_valid_o && range_sum_o == '0;

  `LRAST_ASSERT(a_strobe_idle, range_sum_valid_o |-> !busy, "strobe while busy")
  `LRAST_ASSERT_NEXT(a_no_result_update, upd_acc, !range_sum_valid_o, "result after update word")
  `LRAST_ASSERT_NEXT(a_empty_zero, empty_qry, zero_strobe, "empty query not zero")

endmodule

bind lazy_range_add_set_sum_tree lrast_checker u_lrast_checker (.*);
